[design/kpss_pkg.sv]
`default_nettype none

package kpss_pkg;

    typedef struct packed {
        logic [3:0] col_sense;
        logic [3:0] row_sense;
    } t_in;

    typedef struct packed {
        logic [2:0] digit_select;
        logic [7:0] segments;
        logic       key_valid;
        logic [4:0] key_code;
    } t_out;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_RELEASE  = 2'd2
    } t_phase;

    localparam logic [3:0] LINES_IDLE   = 4'hF;
    localparam logic [4:0] CODE_NOMATCH = 5'd16;
    localparam logic [7:0] DEBOUNCE_RST = 8'd8;
    localparam logic [7:0] COUNT_MAX    = 8'hFF;

    localparam logic [7:0] KEY_PATTERN [16] = '{
        8'h77, 8'h7B, 8'h7D, 8'h7E,
        8'hB7, 8'hBB, 8'hBD, 8'hBE,
        8'hD7, 8'hDB, 8'hDD, 8'hDE,
        8'hE7, 8'hEB, 8'hED, 8'hEE
    };

    // Key number 1..16 of a sensed row/column byte; no match reads as 16.
    function automatic logic [4:0] match_key(input logic [7:0] pat);
        logic [4:0] code;
        code = CODE_NOMATCH;
        for (int k = 15; k >= 0; k--) begin
            if (KEY_PATTERN[k] == pat) begin
                code = 5'(k + 1);
            end
        end
        return code;
    endfunction

    // Common cathode pattern of a stored value; anything above 15 is blank.
    function automatic logic [7:0] seg_code(input logic [4:0] val);
        logic [7:0] seg;
        case (val)
            5'd0:    seg = 8'h71;
            5'd1:    seg = 8'h79;
            5'd2:    seg = 8'h5e;
            5'd3:    seg = 8'h39;
            5'd4:    seg = 8'h7c;
            5'd5:    seg = 8'h77;
            5'd6:    seg = 8'h6f;
            5'd7:    seg = 8'h7f;
            5'd8:    seg = 8'h07;
            5'd9:    seg = 8'h7d;
            5'd10:   seg = 8'h6d;
            5'd11:   seg = 8'h66;
            5'd12:   seg = 8'h4f;
            5'd13:   seg = 8'h5b;
            5'd14:   seg = 8'h06;
            5'd15:   seg = 8'h3f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

[design/keypad_scan_seven_segment_display.sv]
`default_nettype none
// Keypad scanner and multiplexed display: one result transfer per input transfer.
// Each result is registered into the result buffer on its input transfer.
// Throughput: 1 item per cycle; a 2-entry result buffer keeps input open while
// one result waits, so input stalls only when both entries are full.
// Reset (i_rst_n low, synchronous): key FSM idle, pointers at 0, ring cleared
// to 0 (shows F), debounce register back to 8, result buffer emptied.
module keypad_scan_seven_segment_display
    import kpss_pkg::*;
#(
    parameter int NUM_DIGITS = 8
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [7:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out       o_out_data
);

    localparam int IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_DIGITS - 1);

    // Configuration and key FSM state
    logic [7:0]    r_ticks;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_count, n_count;
    logic [4:0]    r_ring [NUM_DIGITS];
    logic [IW-1:0] r_wptr, n_wptr;
    logic [IW-1:0] r_scan, n_scan;

    // Two-entry result buffer: entry 0 is the head shown on the output.
    logic r_v0, r_v1;
    t_out r_d0, r_d1;

    logic in_xfer, out_xfer;
    logic n_store;
    logic [4:0] n_code;
    logic [7:0] cnt_inc;
    t_out n_res;

    assign o_in_ready  = !r_v1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_v0;
    assign o_out_data  = r_d0;
    assign out_xfer    = r_v0 && i_out_ready;

    // Saturating count of debounce ticks
    assign cnt_inc = (r_count < COUNT_MAX) ? r_count + 8'd1 : r_count;

    // Key FSM: next phase, debounce count and store decision for this tick.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_store = 1'b0;
        n_code  = 5'd0;
        unique case (r_phase)
            PH_DEBOUNCE: begin
                n_count = cnt_inc;
                if (cnt_inc >= r_ticks) begin
                    n_count = 8'd0;
                    if (i_in_data.col_sense != LINES_IDLE) begin
                        // Press held through the wait: confirm and store.
                        n_store = 1'b1;
                        n_code  = match_key({i_in_data.row_sense, i_in_data.col_sense});
                        n_phase = PH_RELEASE;
                    end else begin
                        // Press gone at the check: drop it.
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_RELEASE: begin
                if (i_in_data.row_sense == LINES_IDLE) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                // Idle, and the unused phase code behaves as idle.
                n_phase = PH_IDLE;
                if (i_in_data.col_sense != LINES_IDLE) begin
                    n_phase = PH_DEBOUNCE;
                    n_count = 8'd0;
                end
            end
        endcase
    end

    // Pointers advance modulo the digit count.
    assign n_scan = (r_scan == LAST_IDX) ? '0 : r_scan + IW'(1);
    assign n_wptr = (r_wptr == LAST_IDX) ? '0 : r_wptr + IW'(1);

    // Display reads the ring before this tick's store lands.
    always_comb begin
        n_res.digit_select = 3'd7 - 3'(r_scan);
        n_res.segments     = seg_code(r_ring[r_scan]);
        n_res.key_valid    = n_store;
        n_res.key_code     = n_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            r_ticks <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= 8'd0;
            r_wptr  <= '0;
            r_scan  <= '0;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_ring[i] <= 5'd0;
            end
        end else if (in_xfer) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_scan  <= n_scan;
            if (n_store) begin
                r_ring[r_wptr] <= n_code;
                r_wptr         <= n_wptr;
            end
        end
    end

    // Result buffer: shift on pop, fill the first free entry on push.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (out_xfer) begin
            if (r_v1) begin
                r_v1 <= 1'b0;
            end else begin
                r_v0 <= in_xfer;
            end
        end else if (in_xfer) begin
            if (r_v0) begin
                r_v1 <= 1'b1;
            end else begin
                r_v0 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_d0 <= r_v1 ? r_d1 : n_res;
        end else if (in_xfer && !r_v0) begin
            r_d0 <= n_res;
        end
        if (in_xfer && (r_v1 || (r_v0 && !out_xfer))) begin
            r_d1 <= n_res;
        end
    end

`ifndef SYNTHESIS
    a_buf_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> r_v0)
        else $error("second result entry full while head empty");

    a_store_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_store) |=> (r_phase == PH_RELEASE))
        else $error("stored key did not move FSM to release wait");

    a_store_from_debounce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_store) |-> (r_phase == PH_DEBOUNCE))
        else $error("key stored outside debounce phase");

    a_scan_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_scan != LAST_IDX) |=> (r_scan == $past(r_scan) + IW'(1)))
        else $error("scan index did not advance on transfer");
`endif

endmodule

`default_nettype wire
